@@ rtl/core/adsr_pkg.sv @@
package adsr_pkg;

    // Fixed-point format of the level and the additive terms.
    localparam int FRAC_BITS = 22;
    localparam int LVL_W     = 24;
    localparam int COEF_W    = 23;
    localparam int VEL_W     = 7;
    localparam int CFG_IDX_W = 3;

    // Multiply-add widths: full product, truncated quotient, sum with headroom.
    localparam int PROD_W = 2 * LVL_W;
    localparam int QUO_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = QUO_W + 1;

    localparam logic signed [LVL_W-1:0] LVL_ONE  = LVL_W'(1) << FRAC_BITS;
    localparam logic signed [LVL_W-1:0] LVL_ZERO = '0;
    localparam logic signed [LVL_W-1:0] LVL_MAX  = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] LVL_MIN  = {1'b1, {(LVL_W-1){1'b0}}};

    // Velocity scaling: product of level and velocity, divided by 127 through
    // a reciprocal multiply. The quotient is exact for every product below
    // 2^37 / 123, which covers the largest level times the largest velocity.
    localparam int SCALE_W      = COEF_W + VEL_W;
    localparam int RECIP_W      = 31;
    localparam int RECIP_SHIFT  = 37;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 31'd1082196485;
    localparam int SCALED_W     = SCALE_W + RECIP_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd6;

    // Request kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_GATE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic             req_type;
        logic [VEL_W-1:0] gate_value;
    } in_item_t;

    typedef struct packed {
        logic [COEF_W-1:0] env_out;
        phase_t            phase;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick_start;
        logic gate_event;
        logic level_update;
        logic scale_load;
        logic out_load;
    } ctl_cmd_t;

endpackage

@@ rtl/core/adsr_ctrl.sv @@
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_req_type,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   in_xfer;
    logic   out_xfer;
    logic   out_free;

    // Transfers on both channels.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    // Datapath commands follow the current state and the input transfer.
    always_comb
    begin
        cmd              = '0;
        cmd.tick_start   = in_xfer && (in_req_type == REQ_TICK);
        cmd.gate_event   = in_xfer && (in_req_type == REQ_GATE);
        cmd.level_update = (state_reg == ST_ADD);
        cmd.scale_load   = (state_reg == ST_SCALE);
        cmd.out_load     = (state_reg == ST_OUT) && out_free;
    end

    // Sequencer and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result takes precedence over the transfer of the old one.
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.tick_start)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A tick starts the multiply-add sequence; a gate event finishes at once.
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_start |=> state_reg == ST_ADD)
        else $error("accepted tick did not start the update sequence");

    a_gate_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gate_event |=> state_reg == ST_IDLE)
        else $error("gate event left the controller busy");

    // A finished result is posted as soon as the output register is free.
    a_out_posted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result was not posted to the output register");

    // The output register is never overwritten while it holds an untaken result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule

@@ rtl/core/adsr_dpath.sv @@
module adsr_dpath
    import adsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             cmd,
    input  logic [VEL_W-1:0]     gate_value,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LVL_W-1:0]     cfg_data,
    output out_item_t            out_data
);

    // Configuration registers.
    logic        [COEF_W-1:0] attack_coef_reg;
    logic signed [LVL_W-1:0]  attack_base_reg;
    logic        [COEF_W-1:0] decay_coef_reg;
    logic signed [LVL_W-1:0]  decay_base_reg;
    logic        [COEF_W-1:0] release_coef_reg;
    logic signed [LVL_W-1:0]  release_base_reg;
    logic        [COEF_W-1:0] sustain_level_reg;

    // Voice state.
    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic signed [LVL_W-1:0]  level_reg;
    logic signed [LVL_W-1:0]  level_next;
    logic        [VEL_W-1:0]  velocity_reg;

    // Pipeline registers of the tick sequence.
    logic signed [PROD_W-1:0] prod_reg;
    logic        [SCALE_W-1:0] scale_reg;
    out_item_t                out_reg;

    logic        [COEF_W-1:0] coef_sel;
    logic signed [LVL_W-1:0]  base_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [QUO_W-1:0]  quo;
    logic signed [SUM_W-1:0]  sum;
    logic signed [LVL_W-1:0]  sat;
    logic signed [LVL_W-1:0]  sustain_s;
    logic        [COEF_W-1:0] shown;
    logic        [SCALE_W-1:0] scale_next;
    logic        [SCALED_W-1:0] scaled;

    // Coefficient and additive term of the current phase.
    always_comb
    begin
        case (phase_reg)
            PH_ATTACK:
            begin
                coef_sel = attack_coef_reg;
                base_sel = attack_base_reg;
            end
            PH_DECAY:
            begin
                coef_sel = decay_coef_reg;
                base_sel = decay_base_reg;
            end
            PH_RELEASE:
            begin
                coef_sel = release_coef_reg;
                base_sel = release_base_reg;
            end
            default:
            begin
                coef_sel = '0;
                base_sel = '0;
            end
        endcase
    end

    assign prod_next = level_reg * $signed({1'b0, coef_sel});

    // Truncate the product toward zero, add the base and saturate.
    always_comb
    begin
        prod_adj = prod_reg;
        if (prod_reg[PROD_W-1])
        begin
            prod_adj = prod_reg + PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
        end
        quo = prod_adj[PROD_W-1:FRAC_BITS];
        sum = {{(SUM_W-LVL_W){base_sel[LVL_W-1]}}, base_sel} + {quo[QUO_W-1], quo};
        if (sum > $signed({{(SUM_W-LVL_W){LVL_MAX[LVL_W-1]}}, LVL_MAX}))
        begin
            sat = LVL_MAX;
        end
        else if (sum < $signed({{(SUM_W-LVL_W){LVL_MIN[LVL_W-1]}}, LVL_MIN}))
        begin
            sat = LVL_MIN;
        end
        else
        begin
            sat = sum[LVL_W-1:0];
        end
    end

    assign sustain_s = $signed({1'b0, sustain_level_reg});

    // Phase transitions and clamps after the multiply-add.
    always_comb
    begin
        level_next = level_reg;
        phase_next = phase_reg;
        case (phase_reg)
            PH_ATTACK:
            begin
                if (attack_coef_reg == '0 || sat >= LVL_ONE)
                begin
                    level_next = LVL_ONE;
                    phase_next = PH_DECAY;
                end
                else
                begin
                    level_next = sat;
                end
            end
            PH_DECAY:
            begin
                if (sat <= sustain_s)
                begin
                    level_next = sustain_s;
                    phase_next = PH_SUSTAIN;
                end
                else
                begin
                    level_next = sat;
                end
            end
            PH_RELEASE:
            begin
                if (sat <= LVL_ZERO)
                begin
                    level_next = LVL_ZERO;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    level_next = sat;
                end
            end
            default:
            begin
                level_next = level_reg;
                phase_next = phase_reg;
            end
        endcase
    end

    // Velocity scaling: negative levels show as zero, then divide by 127.
    assign shown      = level_reg[LVL_W-1] ? '0 : level_reg[COEF_W-1:0];
    assign scale_next = SCALE_W'(shown) * SCALE_W'(velocity_reg);
    assign scaled     = SCALED_W'(scale_reg) * SCALED_W'(RECIP_MULT);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coef_reg   <= '0;
            attack_base_reg   <= LVL_ONE;
            decay_coef_reg    <= '0;
            decay_base_reg    <= LVL_ONE;
            release_coef_reg  <= '0;
            release_base_reg  <= LVL_ZERO;
            sustain_level_reg <= COEF_W'(LVL_ONE);
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                CFG_ATTACK_COEF:   attack_coef_reg   <= cfg_data[COEF_W-1:0];
                CFG_ATTACK_BASE:   attack_base_reg   <= $signed(cfg_data);
                CFG_DECAY_COEF:    decay_coef_reg    <= cfg_data[COEF_W-1:0];
                CFG_DECAY_BASE:    decay_base_reg    <= $signed(cfg_data);
                CFG_RELEASE_COEF:  release_coef_reg  <= cfg_data[COEF_W-1:0];
                CFG_RELEASE_BASE:  release_base_reg  <= $signed(cfg_data);
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[COEF_W-1:0];
                default:           attack_coef_reg   <= attack_coef_reg;
            endcase
        end
    end

    // Voice state: gate events and the level update of a tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            level_reg    <= LVL_ZERO;
            velocity_reg <= '0;
        end
        else if (cmd.gate_event)
        begin
            if (gate_value != '0)
            begin
                velocity_reg <= gate_value;
                if (phase_reg == PH_IDLE || phase_reg == PH_RELEASE)
                begin
                    level_reg <= LVL_ZERO;
                end
                phase_reg <= PH_ATTACK;
            end
            else if (phase_reg != PH_IDLE)
            begin
                phase_reg <= PH_RELEASE;
            end
        end
        else if (cmd.level_update)
        begin
            level_reg <= level_next;
            phase_reg <= phase_next;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.scale_load)
        begin
            scale_reg <= scale_next;
        end
        if (cmd.out_load)
        begin
            out_reg.env_out <= scaled[RECIP_SHIFT +: COEF_W];
            out_reg.phase   <= phase_reg;
        end
    end

    assign out_data = out_reg;

    // An idle voice always sits at zero level.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> level_reg == LVL_ZERO)
        else $error("idle voice holds a nonzero level");

    // Leaving attack through a tick always lands exactly on full level.
    a_attack_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.level_update && phase_reg == PH_ATTACK && phase_next == PH_DECAY
        |=> level_reg == LVL_ONE)
        else $error("attack ended below or above full level");

endmodule

@@ rtl/core/adsr_envelope_generator.sv @@
// A sample tick's result passes through the product register at the transfer,
// then add and clamp into the level, the velocity multiply and the
// reciprocal scale into the output register; a gate event gives no result.
// A new tick is taken only after the last one's result has entered the output
// register; a result held by a stalled output keeps the next one from entering.
// Reset (rst_n, asynchronous, active low): idle phase, zero level and
// velocity, configuration registers at their documented defaults.
module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LVL_W-1:0]     cfg_data
);

    ctl_cmd_t cmd;

    // Sequencer and handshakes.
    adsr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    // Envelope state, multiply-add and output scaling.
    adsr_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .gate_value (in_data.gate_value),
        .cfg_en     (cfg_en),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .out_data   (out_data)
    );

endmodule

@@ test/adsr_envelope_monitor.sv @@
module adsr_envelope_monitor
    import adsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LVL_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNITY = longint'(1) <<< FRAC_BITS;

    // Shadow copy of the envelope registers.
    logic [COEF_W-1:0]       attack_coef;
    logic signed [LVL_W-1:0] attack_base;
    logic [COEF_W-1:0]       decay_coef;
    logic signed [LVL_W-1:0] decay_base;
    logic [COEF_W-1:0]       release_coef;
    logic signed [LVL_W-1:0] release_base;
    logic [COEF_W-1:0]       sustain_level;

    // Shadow copy of the voice.
    phase_t                  voice_phase;
    logic signed [LVL_W-1:0] voice_level;
    logic [VEL_W-1:0]        voice_velocity;

    // Levels predicted for ticks whose results have not come out yet.
    out_item_t levels_due[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // One multiply-add: full signed product, truncated toward zero, then a
    // saturating add of the base.
    function automatic logic signed [LVL_W-1:0] next_level(
        input logic signed [LVL_W-1:0] base,
        input logic [COEF_W-1:0]       coef
    );
        longint prod;
        longint sum;
        prod = (longint'(voice_level) * longint'(coef)) / UNITY;
        sum  = longint'(base) + prod;
        if (sum > longint'(LVL_MAX))
            sum = longint'(LVL_MAX);
        if (sum < longint'(LVL_MIN))
            sum = longint'(LVL_MIN);
        return LVL_W'(sum);
    endfunction

    // Advances the voice by one transfer; a tick yields one result.
    task automatic advance_voice(
        input  in_item_t  req,
        output bit        has_result,
        output out_item_t res
    );
        longint shown;
        has_result = 1'b0;
        res        = '0;
        if (req.req_type == REQ_GATE)
        begin
            if (req.gate_value != '0)
            begin
                voice_velocity = req.gate_value;
                if (voice_phase == PH_IDLE || voice_phase == PH_RELEASE)
                    voice_level = LVL_ZERO;
                voice_phase = PH_ATTACK;
            end
            else if (voice_phase != PH_IDLE)
            begin
                voice_phase = PH_RELEASE;
            end
        end
        else
        begin
            case (voice_phase)
                PH_ATTACK:
                begin
                    if (attack_coef == '0)
                    begin
                        voice_level = LVL_ONE;
                        voice_phase = PH_DECAY;
                    end
                    else
                    begin
                        voice_level = next_level(attack_base, attack_coef);
                        if (voice_level >= LVL_ONE)
                        begin
                            voice_level = LVL_ONE;
                            voice_phase = PH_DECAY;
                        end
                    end
                end
                PH_DECAY:
                begin
                    voice_level = next_level(decay_base, decay_coef);
                    if (voice_level <= $signed({1'b0, sustain_level}))
                    begin
                        voice_level = $signed({1'b0, sustain_level});
                        voice_phase = PH_SUSTAIN;
                    end
                end
                PH_RELEASE:
                begin
                    voice_level = next_level(release_base, release_coef);
                    if (voice_level <= LVL_ZERO)
                    begin
                        voice_level = LVL_ZERO;
                        voice_phase = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // A negative level shows as zero before the velocity scaling.
            shown = (voice_level < 0) ? 64'sd0 : longint'(voice_level);
            shown = (shown * longint'(voice_velocity)) / 127;
            res.env_out = COEF_W'(shown);
            res.phase   = voice_phase;
            has_result  = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t predicted;
        out_item_t oldest;
        bit        produced;
        if (!rst_n)
        begin
            attack_coef    = '0;
            attack_base    = LVL_ONE;
            decay_coef     = '0;
            decay_base     = LVL_ONE;
            release_coef   = '0;
            release_base   = LVL_ZERO;
            sustain_level  = COEF_W'(LVL_ONE);
            voice_phase    = PH_IDLE;
            voice_level    = LVL_ZERO;
            voice_velocity = '0;
            levels_due.delete();
        end
        else
        begin
            // Register writes.
            if (cfg_en)
            begin
                case (cfg_addr)
                    CFG_ATTACK_COEF:   attack_coef   = cfg_data[COEF_W-1:0];
                    CFG_ATTACK_BASE:   attack_base   = $signed(cfg_data);
                    CFG_DECAY_COEF:    decay_coef    = cfg_data[COEF_W-1:0];
                    CFG_DECAY_BASE:    decay_base    = $signed(cfg_data);
                    CFG_RELEASE_COEF:  release_coef  = cfg_data[COEF_W-1:0];
                    CFG_RELEASE_BASE:  release_base  = $signed(cfg_data);
                    CFG_SUSTAIN_LEVEL: sustain_level = cfg_data[COEF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Output transfers are checked against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (levels_due.size() == 0)
                begin
                    $display("%0t: unexpected result: env_out %0d phase %0d", $time,
                             out_data.env_out, out_data.phase);
                    mismatches++;
                end
                else
                begin
                    oldest = levels_due.pop_front();
                    if (out_data.env_out !== oldest.env_out)
                    begin
                        $display("%0t: env_out expected %0d actual %0d", $time,
                                 oldest.env_out, out_data.env_out);
                        mismatches++;
                    end
                    if (out_data.phase !== oldest.phase)
                    begin
                        $display("%0t: phase expected %0d actual %0d", $time,
                                 oldest.phase, out_data.phase);
                        mismatches++;
                    end
                end
            end

            // Input transfers drive the shadow voice.
            if (in_valid && !in_stall)
            begin
                advance_voice(in_data, produced, predicted);
                if (produced)
                    levels_due.push_back(predicted);
            end
        end
        outstanding = levels_due.size();
    end

endmodule

@@ test/adsr_envelope_generator_tb.sv @@
module adsr_envelope_generator_tb;
    import adsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_Q        = 1 << FRAC_BITS;
    localparam int MAX_Q        = 8388607;
    localparam int MIN_Q        = -8388608;
    localparam int ITEM_TARGET  = 1050;
    localparam int CALM_TAIL    = 120;
    localparam int SHAPES       = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [LVL_W-1:0]     cfg_data  = '0;

    int mismatches;
    int outstanding;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit tail_quiet  = 1'b0;
    bit hold_req    = 1'b0;
    bit sender_calm = 1'b0;

    adsr_envelope_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    adsr_envelope_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_en      (cfg_en),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off.
    initial
    begin : receiver
        int burst;
        int span;
        bit rx_calm;
        burst   = 0;
        span    = 0;
        rx_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    span    = $urandom_range(20, 80);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                span--;
                if (burst > 0)
                    burst--;
                else if (!tail_quiet && !rx_calm && $urandom_range(0, 5) == 0)
                    burst = $urandom_range(1, 10);
                out_stall <= (burst > 0);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offers one request, with an occasional gap before it, and waits for
    // its transfer.
    task automatic send_req(input logic kind, input logic [VEL_W-1:0] vel);
        int gap;
        gap = 0;
        if (!tail_quiet && !hold_req && !sender_calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{req_type: kind, gate_value: vel};
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        items_sent++;
        if (items_sent >= ITEM_TARGET - CALM_TAIL)
            tail_quiet = 1'b1;
    endtask

    // Drops valid and waits until every tick result has come out, plus the
    // latency of a trailing gate event.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_envelope(
        input int acoef, input int abase, input int dcoef, input int dbase,
        input int rcoef, input int rbase, input int sustain
    );
        logic [CFG_IDX_W-1:0] idx [7];
        int                   vals [7];
        idx  = '{CFG_ATTACK_COEF, CFG_ATTACK_BASE, CFG_DECAY_COEF, CFG_DECAY_BASE,
                 CFG_RELEASE_COEF, CFG_RELEASE_BASE, CFG_SUSTAIN_LEVEL};
        vals = '{acoef, abase, dcoef, dbase, rcoef, rbase, sustain};
        for (int k = 0; k < 7; k++)
        begin
            @(negedge clk);
            cfg_en   <= 1'b1;
            cfg_addr <= idx[k];
            cfg_data <= LVL_W'(vals[k]);
        end
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // Mostly slow exponential segments, now and then an instant or frozen one.
    function automatic int pick_coef();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return ONE_Q;
        return $urandom_range(ONE_Q / 2, ONE_Q - ONE_Q / 64);
    endfunction

    // Base that makes the segment approach the given target level.
    function automatic int base_toward(input int target, input int coef);
        return int'((longint'(target) * longint'(ONE_Q - coef)) / longint'(ONE_Q));
    endfunction

    task automatic load_random_envelope();
        int acoef;
        int dcoef;
        int rcoef;
        int sustain;
        int roll;
        acoef = pick_coef();
        dcoef = pick_coef();
        rcoef = pick_coef();
        roll  = $urandom_range(0, 7);
        if (roll == 0)
            sustain = 0;
        else if (roll == 1)
            sustain = ONE_Q;
        else
            sustain = $urandom_range(0, ONE_Q);
        load_envelope(acoef,
                      base_toward(ONE_Q + $urandom_range(ONE_Q / 64, ONE_Q / 2), acoef),
                      dcoef,
                      base_toward(sustain - $urandom_range(1, ONE_Q / 8), dcoef),
                      rcoef,
                      base_toward(-$urandom_range(1, ONE_Q / 8), rcoef),
                      sustain);
    endtask

    // A note: gate on, some ticks with a rare retrigger, gate off, more ticks.
    task automatic play_note();
        int ticks;
        sender_calm = ($urandom_range(0, 3) == 0);
        send_req(REQ_GATE, VEL_W'($urandom_range(1, 127)));
        ticks = $urandom_range(1, 40);
        for (int k = 0; k < ticks; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_req(REQ_GATE, VEL_W'($urandom_range(1, 127)));
            send_req(REQ_TICK, VEL_W'($urandom));
        end
        send_req(REQ_GATE, '0);
        ticks = $urandom_range(1, 40);
        for (int k = 0; k < ticks; k++)
            send_req(REQ_TICK, VEL_W'($urandom));
    endtask

    initial
    begin : stimulus
        int per_shape;
        int shape_end;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Power-on registers: instant attack, decay straight to full sustain,
        // release straight to zero.
        send_req(REQ_TICK, 7'h7F);
        send_req(REQ_GATE, 7'h00);
        send_req(REQ_GATE, 7'h7F);
        send_req(REQ_TICK, 7'h55);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_TICK, 7'h2A);
        send_req(REQ_GATE, 7'h00);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_GATE, 7'h01);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_GATE, 7'h40);
        send_req(REQ_TICK, 7'h00);
        drain();

        // Attack driven to the negative limit, release pulled back by the
        // positive limit.
        load_envelope(ONE_Q, MIN_Q, 0, ONE_Q, ONE_Q, MAX_Q, 0);
        send_req(REQ_GATE, 7'h64);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_GATE, 7'h00);
        send_req(REQ_TICK, 7'h00);
        send_req(REQ_GATE, 7'h7F);
        send_req(REQ_TICK, 7'h00);
        drain();

        // Random notes, one register setting per shape.
        per_shape = (ITEM_TARGET - items_sent) / SHAPES;
        for (int shape = 0; shape < SHAPES; shape++)
        begin
            if (shape == 0)
                load_envelope(ONE_Q, MAX_Q, ONE_Q, MIN_Q, 0, MIN_Q, ONE_Q);
            else
                load_random_envelope();
            if (shape == 2)
                hold_req = 1'b1;
            shape_end = (shape == SHAPES - 1) ? ITEM_TARGET : items_sent + per_shape;
            while (items_sent < shape_end)
            begin
                if ($urandom_range(0, 99) < 85)
                    play_note();
                else
                    send_req(1'($urandom_range(0, 1)), VEL_W'($urandom_range(0, 127)));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
